[hdl/kws_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the keyboard wavetable synthesizer.
// No dependencies; imported by kws_sine_gen, keyboard_wavetable_synth_top and tb_top.
package kws_pkg;

    localparam int TABLE_SIZE_DEF = 48000;
    localparam int SINE_PEAK_DEF  = 8388607;
    localparam int NUM_VOICES_DEF = 8;
    localparam int MAX_VOICES     = 8;

    localparam int SINE_W  = 24;
    localparam int PHASE_W = 32;
    localparam int ACC_W   = 27;
    localparam int SMP_W   = 35;
    localparam int VOL_W   = 8;
    localparam int STEP_W  = 6;
    localparam int INCR_W  = 25;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam logic [30:0] Q30_ONE     = 31'd1073741824;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic REG_VOLUME_STEP = 1'b0;
    localparam logic REG_VOLUME_MAX  = 1'b1;

    localparam logic [7:0] CODE_VOL_UP = 8'h55;
    localparam logic [7:0] CODE_VOL_DN = 8'h4E;
    localparam logic [7:0] CODE_BREAK  = 8'hF0;

    typedef struct packed {
        logic wr_en;
        logic done;
    } t_fill_ctl;

    typedef struct packed {
        logic [2:0]       voice;
        logic             held;
        logic             first;
        logic             last;
        logic [VOL_W-1:0] vol;
    } t_voice_op;

    function automatic logic [7:0] note_code(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0: c = 8'h1C;
            3'd1: c = 8'h1B;
            3'd2: c = 8'h23;
            3'd3: c = 8'h2B;
            3'd4: c = 8'h3B;
            3'd5: c = 8'h42;
            3'd6: c = 8'h4B;
            3'd7: c = 8'h4C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [INCR_W-1:0] note_incr(input logic [2:0] k);
        logic [INCR_W-1:0] v;
        case (k)
            3'd0: v = 25'd8572961;
            3'd1: v = 25'd9622782;
            3'd2: v = 25'd10801250;
            3'd3: v = 25'd11443503;
            3'd4: v = 25'd12844925;
            3'd5: v = 25'd14417920;
            3'd6: v = 25'd16183591;
            3'd7: v = 25'd17145922;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] horner_div(input logic [2:0] k);
        logic [7:0] d;
        case (k)
            3'd0: d = 8'd156;
            3'd1: d = 8'd110;
            3'd2: d = 8'd72;
            3'd3: d = 8'd42;
            3'd4: d = 8'd20;
            3'd5: d = 8'd6;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

[hdl/kws_sine_gen.sv]
`timescale 1ns / 1ps
// Sine table generator: computes one table entry at a time by quadrant folding and a
// fixed-point odd polynomial, using one shared multiplier and an 8-bit-per-cycle divider.
// Depends on kws_pkg.
module kws_sine_gen import kws_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int SINE_PEAK  = SINE_PEAK_DEF,
    localparam int AW = $clog2(TABLE_SIZE)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output t_fill_ctl         o_ctl,
    output logic [AW-1:0]     o_wr_addr,
    output logic [SINE_W-1:0] o_wr_data
);

    localparam logic [15:0]   TS16     = 16'(TABLE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);
    localparam logic [24:0]   PEAK25   = 25'(SINE_PEAK);
    localparam logic [30:0]   PEAK31   = 31'(SINE_PEAK);
    localparam int            DIV_STEPS = 6;

    localparam logic [3:0] G_DIVZ  = 4'd0;
    localparam logic [3:0] G_WAITZ = 4'd1;
    localparam logic [3:0] G_MULY  = 4'd2;
    localparam logic [3:0] G_MULYY = 4'd3;
    localparam logic [3:0] G_Y2    = 4'd4;
    localparam logic [3:0] G_HMUL  = 4'd5;
    localparam logic [3:0] G_HDIV  = 4'd6;
    localparam logic [3:0] G_HWAIT = 4'd7;
    localparam logic [3:0] G_SMUL  = 4'd8;
    localparam logic [3:0] G_VMUL  = 4'd9;
    localparam logic [3:0] G_WRITE = 4'd10;
    localparam logic [3:0] G_DONE  = 4'd11;

    logic [3:0]        r_state;
    logic [AW-1:0]     r_idx;
    logic [15:0]       r_rem;
    logic [1:0]        r_quad;
    logic [30:0]       r_y;
    logic [31:0]       r_y2;
    logic [30:0]       r_t;
    logic [2:0]        r_k;
    logic [62:0]       r_prod;
    logic [47:0]       r_dq;
    logic [15:0]       r_drem;
    logic [15:0]       r_dvs;
    logic [2:0]        r_dcnt;
    logic              r_dbusy;
    logic              r_done;
    logic              r_wr_en;
    logic [AW-1:0]     r_wr_addr;
    logic [SINE_W-1:0] r_wr_data;

    logic [31:0]       m_a;
    logic [30:0]       m_b;
    logic              mul_en;
    logic              div_start;
    logic [47:0]       div_dend;
    logic [15:0]       div_dvs;
    logic [47:0]       d_dq;
    logic [15:0]       d_rem;
    logic [16:0]       d_part;
    logic [15:0]       fold;
    logic [16:0]       rem4;
    logic [54:0]       v_round;
    logic [24:0]       v_cap;
    logic [SINE_W-1:0] v_mag;

    assign fold = r_quad[0] ? (TS16 - r_rem) : r_rem;
    assign rem4 = {1'b0, r_rem} + 17'd4;

    always_comb begin
        mul_en = 1'b0;
        m_a    = r_y2;
        m_b    = r_t;
        case (r_state)
            G_MULY: begin
                mul_en = 1'b1;
                m_a    = {1'b0, r_dq[30:0]};
                m_b    = HALF_PI_Q30;
            end
            G_MULYY: begin
                mul_en = 1'b1;
                m_a    = {1'b0, r_prod[60:30]};
                m_b    = r_prod[60:30];
            end
            G_HMUL: begin
                mul_en = 1'b1;
            end
            G_SMUL: begin
                mul_en = 1'b1;
                m_a    = {1'b0, r_y};
            end
            G_VMUL: begin
                mul_en = 1'b1;
                m_a    = {1'b0, r_prod[60:30]};
                m_b    = PEAK31;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_dend  = {2'b00, fold, 30'd0};
        div_dvs   = TS16;
        case (r_state)
            G_DIVZ: begin
                div_start = 1'b1;
            end
            G_HDIV: begin
                div_start = 1'b1;
                div_dend  = {16'd0, r_prod[61:30]};
                div_dvs   = {8'd0, horner_div(r_k)};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        d_rem  = r_drem;
        d_dq   = r_dq;
        d_part = '0;
        for (int i = 0; i < 8; i++) begin
            d_part = {d_rem, d_dq[47]};
            d_dq   = {d_dq[46:0], 1'b0};
            if (d_part >= {1'b0, r_dvs}) begin
                d_rem   = 16'(d_part - {1'b0, r_dvs});
                d_dq[0] = 1'b1;
            end else begin
                d_rem = d_part[15:0];
            end
        end
    end

    assign v_round = 55'(r_prod[53:0]) + 55'(32'd536870912);
    assign v_cap   = (v_round[54:30] > PEAK25) ? PEAK25 : v_round[54:30];
    assign v_mag   = v_cap[SINE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= m_a * m_b;
        end
        if (div_start) begin
            r_dq   <= div_dend;
            r_drem <= '0;
            r_dvs  <= div_dvs;
        end else if (r_dbusy) begin
            r_dq   <= d_dq;
            r_drem <= d_rem;
        end
        if (r_state == G_MULYY) begin
            r_y <= r_prod[60:30];
        end
        if (r_state == G_Y2) begin
            r_y2 <= r_prod[61:30];
        end
        if (r_state == G_Y2) begin
            r_t <= Q30_ONE;
        end else if (r_state == G_HWAIT && !r_dbusy) begin
            r_t <= Q30_ONE - r_dq[30:0];
        end
        if (r_state == G_WRITE) begin
            r_wr_addr <= r_idx;
            r_wr_data <= r_quad[1] ? (SINE_W'(0) - v_mag) : v_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_DIVZ;
            r_idx   <= '0;
            r_rem   <= '0;
            r_quad  <= '0;
            r_k     <= '0;
            r_dcnt  <= '0;
            r_dbusy <= 1'b0;
            r_done  <= 1'b0;
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= (r_state == G_WRITE);
            if (div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 3'd1;
                if (r_dcnt == 3'(DIV_STEPS - 1)) begin
                    r_dbusy <= 1'b0;
                end
            end
            case (r_state)
                G_DIVZ: begin
                    r_state <= G_WAITZ;
                end
                G_WAITZ: begin
                    if (!r_dbusy) begin
                        r_state <= G_MULY;
                    end
                end
                G_MULY: begin
                    r_state <= G_MULYY;
                end
                G_MULYY: begin
                    r_state <= G_Y2;
                end
                G_Y2: begin
                    r_k     <= '0;
                    r_state <= G_HMUL;
                end
                G_HMUL: begin
                    r_state <= G_HDIV;
                end
                G_HDIV: begin
                    r_state <= G_HWAIT;
                end
                G_HWAIT: begin
                    if (!r_dbusy) begin
                        if (r_k == 3'd5) begin
                            r_state <= G_SMUL;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= G_HMUL;
                        end
                    end
                end
                G_SMUL: begin
                    r_state <= G_VMUL;
                end
                G_VMUL: begin
                    r_state <= G_WRITE;
                end
                G_WRITE: begin
                    if (rem4 >= {1'b0, TS16}) begin
                        r_rem  <= 16'(rem4 - {1'b0, TS16});
                        r_quad <= r_quad + 2'd1;
                    end else begin
                        r_rem <= rem4[15:0];
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= G_DONE;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= G_DIVZ;
                    end
                end
                G_DONE: begin
                    r_done <= 1'b1;
                end
                default: begin
                    r_state <= G_DIVZ;
                end
            endcase
        end
    end

    assign o_ctl.wr_en = r_wr_en;
    assign o_ctl.done  = r_done;
    assign o_wr_addr   = r_wr_addr;
    assign o_wr_data   = r_wr_data;

`ifndef SYNTH
    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dbusy |-> (r_state == G_WAITZ || r_state == G_HWAIT))
        else $error("divider running outside a wait state");
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("fill done flag dropped");
    a_no_write_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_state) == G_DONE && !r_wr_en)
        else $error("table write after fill completed");
`endif

endmodule

[hdl/keyboard_wavetable_synth_top.sv]
`timescale 1ns / 1ps
// Stages: phase read (r_s1), sine read and accumulate (r_s2), volume scale and queue write (r_s3).
// Voices issue in turn, one phase-memory read each; scan bytes one a cycle while s_axis_tready is high.
// Reset: the sine table is rebuilt by kws_sine_gen while s_axis_tready stays low; configuration writes
// are taken during that time.
// Up to OQ_DEPTH results are buffered; the input also stalls when all are reserved or a tick is issuing.
module keyboard_wavetable_synth_top import kws_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int SINE_PEAK  = SINE_PEAK_DEF,
    parameter int NUM_VOICES = NUM_VOICES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] scan_code
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [34:0] audio_sample, [42:35] volume_now
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int VD = 1 << VW;
    localparam int OQ_W = SMP_W + VOL_W;
    localparam logic [VW-1:0] LAST_V  = VW'(NUM_VOICES - 1);
    localparam logic [32:0]   PH_WRAP = {1'b0, 16'(TABLE_SIZE), 16'd0};

    t_fill_ctl         fill;
    logic [AW-1:0]     gen_addr;
    logic [SINE_W-1:0] gen_data;

    logic [STEP_W-1:0] r_vol_step;
    logic [VOL_W-1:0]  r_vol_max;
    logic [VOL_W-1:0]  r_volume;
    logic [7:0]        r_held;
    logic              r_break;

    logic              in_fire;
    logic              tick_fire;
    logic              scan_fire;
    logic              note_hit;
    logic [2:0]        note_idx;
    logic [8:0]        vol_up;

    logic              r_busy;
    logic [VW-1:0]     r_vcnt;
    logic              issue_vld;
    logic [VW-1:0]     issue_voice;
    t_voice_op         issue_op;

    logic [PHASE_W-1:0] r_ph_mem [0:VD-1];
    logic [VD-1:0]      r_ph_vld;
    logic [PHASE_W-1:0] r_ph_q;
    logic               r_ph_vq;
    logic               r_fwd;
    logic [PHASE_W-1:0] r_fwd_val;

    logic [SINE_W-1:0]        r_sin_mem [0:TABLE_SIZE-1];
    logic signed [SINE_W-1:0] r_sin_q;

    logic              r_s1_vld;
    t_voice_op         r_s1;
    logic              r_s2_vld;
    t_voice_op         r_s2;
    logic              r_s3_vld;
    t_voice_op         r_s3;

    logic [VW-1:0]      s1_vidx;
    logic [PHASE_W-1:0] ph_cur;
    logic [32:0]        ph_sum;
    logic [PHASE_W-1:0] ph_new;
    logic [AW-1:0]      sin_addr;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] term;
    logic signed [SMP_W-1:0] smp;

    logic [OQ_W-1:0]  r_oq_mem [0:OQ_DEPTH-1];
    logic [OQ_AW-1:0] r_oq_wp;
    logic [OQ_AW-1:0] r_oq_rp;
    logic [OQ_AW:0]   r_oq_cnt;
    logic [OQ_AW:0]   r_resv;
    logic             oq_pop;

    kws_sine_gen #(
        .TABLE_SIZE (TABLE_SIZE),
        .SINE_PEAK  (SINE_PEAK)
    ) u_sine_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_ctl     (fill),
        .o_wr_addr (gen_addr),
        .o_wr_data (gen_data)
    );

    assign s_axis_tready = fill.done && !r_busy && (r_resv != (OQ_AW + 1)'(OQ_DEPTH));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign tick_fire     = in_fire && s_axis_tuser;
    assign scan_fire     = in_fire && !s_axis_tuser;
    assign vol_up        = {1'b0, r_volume} + 9'(r_vol_step);

    always_comb begin
        note_hit = 1'b0;
        note_idx = '0;
        for (int k = 0; k < MAX_VOICES; k++) begin
            if (k < NUM_VOICES && s_axis_tdata == note_code(3'(k))) begin
                note_hit = 1'b1;
                note_idx = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_step <= STEP_W'(10);
            r_vol_max  <= VOL_W'(250);
            r_volume   <= VOL_W'(100);
            r_held     <= '0;
            r_break    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_VOLUME_STEP: r_vol_step <= i_cfg_data[STEP_W-1:0];
                    REG_VOLUME_MAX:  r_vol_max  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (scan_fire) begin
                if (r_break) begin
                    r_break <= 1'b0;
                    if (note_hit) begin
                        r_held[note_idx] <= 1'b0;
                    end
                end else if (note_hit) begin
                    r_held[note_idx] <= 1'b1;
                end else if (s_axis_tdata == CODE_VOL_UP) begin
                    r_volume <= (vol_up > {1'b0, r_vol_max}) ? r_vol_max : vol_up[7:0];
                end else if (s_axis_tdata == CODE_VOL_DN) begin
                    r_volume <= (r_volume < VOL_W'(r_vol_step)) ? '0
                                : r_volume - VOL_W'(r_vol_step);
                end else if (s_axis_tdata == CODE_BREAK) begin
                    r_break <= 1'b1;
                end
            end
        end
    end

    // Voice sequencer: the accepting cycle issues voice 0, the following cycles the rest.
    assign issue_vld      = tick_fire || r_busy;
    assign issue_voice    = r_busy ? r_vcnt : '0;
    assign issue_op.voice = 3'(issue_voice);
    assign issue_op.held  = r_held[3'(issue_voice)];
    assign issue_op.first = !r_busy;
    assign issue_op.last  = (issue_voice == LAST_V);
    assign issue_op.vol   = r_volume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vcnt <= '0;
        end else if (tick_fire) begin
            r_busy <= (NUM_VOICES > 1);
            r_vcnt <= VW'(1);
        end else if (r_busy) begin
            if (r_vcnt == LAST_V) begin
                r_busy <= 1'b0;
            end else begin
                r_vcnt <= r_vcnt + VW'(1);
            end
        end
    end

    assign s1_vidx  = r_s1.voice[VW-1:0];
    assign ph_cur   = r_fwd ? r_fwd_val : (r_ph_vq ? r_ph_q : '0);
    assign ph_sum   = {1'b0, ph_cur} + 33'(note_incr(r_s1.voice));
    assign ph_new   = (ph_sum >= PH_WRAP) ? 32'(ph_sum - PH_WRAP) : ph_sum[31:0];
    assign sin_addr = ph_cur[16 +: AW];

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_ph_mem[s1_vidx] <= ph_new;
        end
        r_ph_q <= r_ph_mem[issue_voice];
    end

    always_ff @(posedge i_clk) begin
        if (fill.wr_en) begin
            r_sin_mem[gen_addr] <= gen_data;
        end
        r_sin_q <= r_sin_mem[sin_addr];
    end

    always_ff @(posedge i_clk) begin
        r_ph_vq   <= r_ph_vld[issue_voice];
        r_fwd_val <= ph_new;
        r_s1      <= issue_op;
        r_s2      <= r_s1;
        r_s3      <= r_s2;
        if (!i_rst_n) begin
            r_ph_vld <= '0;
            r_fwd    <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (r_s1_vld) begin
                r_ph_vld[s1_vidx] <= 1'b1;
            end
            r_fwd    <= r_s1_vld && issue_vld && (s1_vidx == issue_voice);
            r_s1_vld <= issue_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld && r_s2.last;
        end
    end

    assign term = r_s2.held ? ACC_W'(r_sin_q) : '0;
    assign smp  = r_acc * $signed({1'b0, r_s3.vol});

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_acc <= r_s2.first ? term : r_acc + term;
        end
        if (r_s3_vld) begin
            r_oq_mem[r_oq_wp] <= {r_s3.vol, smp};
        end
    end

    assign oq_pop        = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_oq_cnt != '0);
    assign m_axis_tdata  = 48'(r_oq_mem[r_oq_rp]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
            r_resv   <= '0;
        end else begin
            if (r_s3_vld) begin
                r_oq_wp <= r_oq_wp + OQ_AW'(1);
            end
            if (oq_pop) begin
                r_oq_rp <= r_oq_rp + OQ_AW'(1);
            end
            r_oq_cnt <= r_oq_cnt + (OQ_AW + 1)'(r_s3_vld) - (OQ_AW + 1)'(oq_pop);
            r_resv   <= r_resv + (OQ_AW + 1)'(tick_fire) - (OQ_AW + 1)'(oq_pop);
        end
    end

`ifndef SYNTH
    a_queue_within_reserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= r_resv)
        else $error("result queue holds more entries than reserved requests");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && !oq_pop) |-> r_oq_cnt < (OQ_AW + 1)'(OQ_DEPTH))
        else $error("result pushed into a full queue");
    a_fwd_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> $past(r_s1_vld) && $past(issue_vld))
        else $error("phase forward without an overlapping write");
    a_held_stable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $stable(r_held) && $stable(r_volume))
        else $error("note or volume state changed during a tick");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for keyboard_wavetable_synth_top: scan and tick requests go in on the
// input stream, and each tick's sample is checked against a built-in model of the synthesizer.
// Depends on kws_pkg and keyboard_wavetable_synth_top.
module tb_top;
    import kws_pkg::*;

    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam int CLK_HALF = 5;
    localparam int END_PAUSE = 4 * (NUM_VOICES_DEF + 3);
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam longint unsigned ROM_SIZE = 64'd48000;
    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam longint unsigned HALF_PI = 64'd1686629713;
    localparam longint unsigned PHASE_WRAP = ROM_SIZE << 16;

    localparam logic [7:0][7:0] NOTE_KEY = {8'h4C, 8'h4B, 8'h42, 8'h3B,
                                            8'h2B, 8'h23, 8'h1B, 8'h1C};
    localparam logic [7:0][24:0] NOTE_STEP = {25'd17145922, 25'd16183591, 25'd14417920,
                                              25'd12844925, 25'd11443503, 25'd10801250,
                                              25'd9622782, 25'd8572961};

    typedef struct packed {
        logic       mode;
        logic [7:0] code;
    } key_req_t;

    typedef struct packed {
        logic [34:0] sample;
        logic [7:0]  vol;
    } synth_out_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] scan_code
    logic        s_axis_tuser = 1'b0;  // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [34:0] audio_sample, [42:35] volume_now
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [7:0]  i_cfg_data = '0;

    key_req_t   pend_q[$];
    synth_out_t sample_q[$];

    logic [5:0]  vol_step = 6'd10;
    logic [7:0]  vol_max = 8'd250;
    logic [7:0]  held;
    logic        brk_armed;
    logic [7:0]  volume;
    logic [31:0] phase_acc [8];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    int errors = 0;
    int cycles = 0;

    keyboard_wavetable_synth_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic longint sine_value(input logic [15:0] idx16);
        longint unsigned idx, t4, quad, rem, z, y, y2, t, s, v;
        idx = idx16;
        if (idx >= ROM_SIZE) begin
            idx = 0;
        end
        t4 = idx * 4;
        quad = t4 / ROM_SIZE;
        rem = t4 - quad * ROM_SIZE;
        if (quad[0]) begin
            rem = ROM_SIZE - rem;
        end
        z = (rem << 30) / ROM_SIZE;
        y = (z * HALF_PI) >> 30;
        y2 = (y * y) >> 30;
        t = Q30;
        t = Q30 - ((y2 * t) >> 30) / 156;
        t = Q30 - ((y2 * t) >> 30) / 110;
        t = Q30 - ((y2 * t) >> 30) / 72;
        t = Q30 - ((y2 * t) >> 30) / 42;
        t = Q30 - ((y2 * t) >> 30) / 20;
        t = Q30 - ((y2 * t) >> 30) / 6;
        s = (y * t) >> 30;
        v = (s * 64'd8388607 + (64'd1 << 29)) >> 30;
        if (v > 64'd8388607) begin
            v = 64'd8388607;
        end
        return (quad >= 2) ? -longint'(v) : longint'(v);
    endfunction

    // Input driver; it also advances the synthesizer model on every accepted request.
    always @(posedge i_clk) begin
        key_req_t req;
        longint acc;
        longint unsigned nxt;
        int note;
        int k;
        int up;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            held = '0;
            brk_armed = 1'b0;
            volume = 8'd100;
            for (k = 0; k < 8; k++) begin
                phase_acc[k] = '0;
            end
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == MODE_TICK) begin
                    acc = 0;
                    for (k = 0; k < 8; k++) begin
                        if (held[k]) begin
                            acc += sine_value(phase_acc[k][31:16]);
                        end
                        nxt = longint'(phase_acc[k]) + NOTE_STEP[k];
                        if (nxt >= PHASE_WRAP) begin
                            nxt -= PHASE_WRAP;
                        end
                        phase_acc[k] = nxt[31:0];
                    end
                    acc *= longint'(volume);
                    sample_q.push_back('{sample: acc[34:0], vol: volume});
                end else begin
                    note = -1;
                    for (k = 0; k < 8; k++) begin
                        if (s_axis_tdata == NOTE_KEY[k]) begin
                            note = k;
                        end
                    end
                    up = int'(volume) + int'(vol_step);
                    if (brk_armed) begin
                        brk_armed = 1'b0;
                        if (note >= 0) begin
                            held[note] = 1'b0;
                        end
                    end else if (note >= 0) begin
                        held[note] = 1'b1;
                    end else if (s_axis_tdata == CODE_VOL_UP) begin
                        volume = (up > int'(vol_max)) ? vol_max : up[7:0];
                    end else if (s_axis_tdata == CODE_VOL_DN) begin
                        volume = (volume < vol_step) ? 8'd0 : volume - vol_step;
                    end else if (s_axis_tdata == CODE_BREAK) begin
                        brk_armed = 1'b1;
                    end
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pend_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    req = pend_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= req.mode;
                    s_axis_tdata <= req.code;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        synth_out_t want;
        synth_out_t got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.sample = m_axis_tdata[34:0];
                got.vol = m_axis_tdata[42:35];
                if (sample_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected sample %0d, volume %0d",
                                 $signed(got.sample), got.vol);
                    end
                end else begin
                    want = sample_q.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("sample mismatch: expected %0d vol %0d, got %0d vol %0d",
                                     $signed(want.sample), want.vol,
                                     $signed(got.sample), got.vol);
                        end
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic push_req(input logic mode, input logic [7:0] code);
        pend_q.push_back('{mode: mode, code: code});
    endtask

    // Mostly well-formed key traffic: note presses, releases, volume keys and ticks,
    // with stray bytes and broken break sequences mixed in.
    task automatic queue_random(input int n, input int tick_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < tick_pct) begin
                push_req(MODE_TICK, ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00);
            end else if (r < tick_pct + 20) begin
                push_req(MODE_SCAN, NOTE_KEY[$urandom_range(7)]);
            end else if (r < tick_pct + 33) begin
                push_req(MODE_SCAN, CODE_BREAK);
                push_req(MODE_SCAN, NOTE_KEY[$urandom_range(7)]);
            end else if (r < tick_pct + 45) begin
                push_req(MODE_SCAN, ($urandom_range(1) == 1) ? CODE_VOL_UP : CODE_VOL_DN);
            end else if (r < tick_pct + 55) begin
                push_req(MODE_SCAN, 8'($urandom_range(255)));
            end else begin
                push_req(MODE_SCAN, CODE_BREAK);
                push_req(MODE_SCAN, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == REG_VOLUME_STEP) begin
            vol_step = val[5:0];
        end else begin
            vol_max = val;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Scan requests give no sample, so the extra pause lets the last of them settle.
    task automatic drain();
        while (pend_q.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (sample_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_PAUSE) @(posedge i_clk);
    endtask

    initial begin
        int ph;
        int step_set [4];
        int max_set [4];
        int tx_set [4];
        int rx_set [4];
        int k;
        step_set = '{50, 0, 1, 50};
        max_set = '{230, 0, 255, 120};
        tx_set = '{0, 85, 0, 38};
        rx_set = '{0, 0, 85, 38};
        step_set[2] = $urandom_range(1, 50);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                drain();
            end
            write_reg(REG_VOLUME_STEP, 8'(step_set[ph]));
            write_reg(REG_VOLUME_MAX, 8'(max_set[ph]));
            @(negedge i_clk);
            tx_idle_pct = tx_set[ph];
            rx_stall_pct = rx_set[ph];
            if (ph == 0) begin
                push_req(MODE_TICK, 8'h00);
                for (k = 0; k < 8; k++) begin
                    push_req(MODE_SCAN, NOTE_KEY[k]);
                end
                push_req(MODE_TICK, 8'hFF);
                repeat (3) push_req(MODE_SCAN, CODE_VOL_UP);
                push_req(MODE_SCAN, CODE_BREAK);
                push_req(MODE_SCAN, NOTE_KEY[0]);
                push_req(MODE_TICK, 8'h00);
                push_req(MODE_SCAN, CODE_BREAK);
                push_req(MODE_TICK, 8'h00);
                push_req(MODE_SCAN, CODE_VOL_UP);
                push_req(MODE_TICK, 8'h00);
                push_req(MODE_SCAN, CODE_BREAK);
                push_req(MODE_SCAN, CODE_BREAK);
                push_req(MODE_SCAN, 8'hFF);
                push_req(MODE_SCAN, CODE_VOL_DN);
                push_req(MODE_TICK, 8'h00);
                drain();
                hold_req = 1'b1;
                queue_random(85, 60);
            end else begin
                queue_random(105, 35);
            end
        end
        drain();
        if (errors == 0 && sample_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
